/* rtl/mbw_pkg.sv */
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared widths, register codes, engine states and the result beat layout
// of the spanning-tree bottleneck block.
// ----------------------------------------------------------------------------
package mbw_pkg;

	// Parameter defaults
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_WEIGHT_BITS  = 16;

	// Fixed field widths of the stream beats
	localparam int VTX_W      = 6;
	localparam int FLD_WGT_W  = 16;
	localparam int RES_W      = 16;
	localparam int S_TDATA_W  = 32;

	// Configuration register
	localparam int VC_W    = 7;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam logic [VC_W-1:0] VC_RESET = 7'd1;

	// Register select code carried on paddr[APB_AW-1]
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Graph tag kept beside each stored weight; tag zero marks a cleared entry
	localparam int EPOCH_W = 8;

	// Tree walk sequencer
	typedef enum logic [2:0] {
		PS_IDLE,
		PS_SELECT,
		PS_PASS,
		PS_DRAIN,
		PS_DECIDE,
		PS_DONE
	} prim_state_t;

	typedef struct packed {
		logic             impossible;
		logic [RES_W-1:0] max_weight;
	} result_t;

endpackage

/* rtl/mbw_cfg.sv */
// ----------------------------------------------------------------------------
// mbw_cfg
// APB register for the vertex count, with readback and the clamp of the
// count to the range the engine can walk.
// ----------------------------------------------------------------------------
module mbw_cfg #(
	parameter int MAX_VERTICES = mbw_pkg::DEF_MAX_VERTICES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mbw_pkg::APB_AW-1:0]         paddr,
	input  logic [mbw_pkg::APB_DW-1:0]         pwdata,
	output logic [mbw_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	output logic [$clog2(MAX_VERTICES+1)-1:0]  vtx_active
);
	import mbw_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > VC_W) ? CNT_W : VC_W;

	logic [VC_W-1:0]  vertex_count_q;
	logic             reg_sel;
	logic             reg_wr;
	logic [CMP_W-1:0] vc_ext;
	logic [CMP_W-1:0] vc_clamped;

	assign reg_sel = (paddr[APB_AW-1] == REG_VERTEX_COUNT);
	assign reg_wr  = psel & penable & pwrite & reg_sel;
	assign pready  = 1'b1;

	// Hold the register; write on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (reg_wr) begin
			vertex_count_q <= pwdata[VC_W-1:0];
		end
	end

	assign prdata = reg_sel ? APB_DW'(vertex_count_q) : '0;

	// Clamp: zero counts as one vertex, large counts saturate
	always_comb begin
		vc_ext = CMP_W'(vertex_count_q);
		priority if (vc_ext == '0) begin
			vc_clamped = CMP_W'(1);
		end else if (vc_ext > CMP_W'(MAX_VERTICES)) begin
			vc_clamped = CMP_W'(MAX_VERTICES);
		end else begin
			vc_clamped = vc_ext;
		end
	end

	assign vtx_active = CNT_W'(vc_clamped);

endmodule

/* rtl/mbw_edge_store.sv */
// ----------------------------------------------------------------------------
// mbw_edge_store
// Edge weight memory, one entry per unordered vertex pair, tagged with the
// graph epoch. Loads run a read-modify-write, read then compare and write,
// with forwarding of the previous write; the tree walk shares the read port. A
// clearing sweep zeroes all tags after reset and whenever the epoch wraps.
// ----------------------------------------------------------------------------
module mbw_edge_store #(
	parameter int MAX_VERTICES = mbw_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = mbw_pkg::DEF_WEIGHT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]  vtx_active,
	// load beat
	input  logic                               ld_beat,
	input  logic [mbw_pkg::VTX_W-1:0]          ld_from,
	input  logic [mbw_pkg::VTX_W-1:0]          ld_to,
	input  logic [mbw_pkg::FLD_WGT_W-1:0]      ld_weight,
	// walk read
	input  logic                               scan_en,
	input  logic [$clog2(MAX_VERTICES)-1:0]    scan_a,
	input  logic [$clog2(MAX_VERTICES)-1:0]    scan_b,
	output logic                               scan_hit,
	output logic [WEIGHT_BITS-1:0]             scan_weight,
	// graph lifecycle
	input  logic                               graph_done,
	output logic                               clearing
);
	import mbw_pkg::*;

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VB;
	localparam int DEPTH = 1 << AW;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > VTX_W) ? CNT_W : VTX_W;
	localparam int EW    = WEIGHT_BITS + EPOCH_W;

	function automatic logic [AW-1:0] pair_addr(input logic [VB-1:0] a,
		input logic [VB-1:0] b);
		if (a < b) begin
			return {a, b};
		end
		return {b, a};
	endfunction

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	logic [EPOCH_W-1:0]     epoch_q;
	logic                   clr_q;
	logic [AW-1:0]          clr_addr_q;

	logic [WEIGHT_BITS-1:0] ld_w;
	logic [CMP_W-1:0]       n_ext;
	logic                   ld_ok;
	logic [AW-1:0]          ld_addr;

	logic                   ld_vld_s1;
	logic [AW-1:0]          ld_addr_s1;
	logic [WEIGHT_BITS-1:0] ld_w_s1;

	logic                   wr_vld_q;
	logic [AW-1:0]          wr_addr_q;
	logic [WEIGHT_BITS-1:0] wr_w_q;

	logic                   fwd_hit;
	logic                   cur_hit;
	logic [WEIGHT_BITS-1:0] cur_w;
	logic                   ld_we;

	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [EW-1:0]          mem_wd;
	logic [AW-1:0]          mem_ra;

	// Qualify the edge: drop zero weight, self-loops and endpoints out of range
	assign ld_w    = WEIGHT_BITS'(ld_weight);
	assign n_ext   = CMP_W'(vtx_active);
	assign ld_ok   = ld_beat && (ld_w != '0) && (ld_from != ld_to) &&
	                 (CMP_W'(ld_from) < n_ext) && (CMP_W'(ld_to) < n_ext);
	assign ld_addr = pair_addr(VB'(ld_from), VB'(ld_to));

	assign mem_ra  = scan_en ? pair_addr(scan_a, scan_b) : ld_addr;

	// Compare against the stored entry, or the write just made to it
	assign fwd_hit = wr_vld_q && (wr_addr_q == ld_addr_s1);
	assign cur_hit = fwd_hit || (rd_q[EW-1:WEIGHT_BITS] == epoch_q);
	assign cur_w   = fwd_hit ? wr_w_q : rd_q[WEIGHT_BITS-1:0];
	assign ld_we   = ld_vld_s1 && (!cur_hit || (cur_w > ld_w_s1));

	// Write port: clearing sweep or the load stage
	assign mem_we  = clr_q || ld_we;
	assign mem_wa  = clr_q ? clr_addr_q : ld_addr_s1;
	assign mem_wd  = clr_q ? '0 : {epoch_q, ld_w_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// Walk read result
	assign scan_hit    = (rd_q[EW-1:WEIGHT_BITS] == epoch_q);
	assign scan_weight = rd_q[WEIGHT_BITS-1:0];

	// Load stage payload
	always_ff @(posedge clk) begin
		ld_addr_s1 <= ld_addr;
		ld_w_s1    <= ld_w;
		wr_addr_q  <= ld_addr_s1;
		wr_w_q     <= ld_w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_vld_s1 <= 1'b0;
			wr_vld_q  <= 1'b0;
		end else begin
			ld_vld_s1 <= ld_ok;
			wr_vld_q  <= ld_we;
		end
	end

	// Epoch advance per graph; sweep the tags when it wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			epoch_q    <= EPOCH_W'(1);
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_q   <= 1'b0;
				epoch_q <= EPOCH_W'(1);
			end
		end else if (graph_done) begin
			if (epoch_q == '1) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + 1'b1;
			end
		end
	end

	assign clearing = clr_q;

endmodule

/* rtl/mbw_prim.sv */
// ----------------------------------------------------------------------------
// mbw_prim
// Dense Prim walk from vertex 0. Each round marks the picked vertex, then
// sweeps all active vertices once: reads the edge to the pick and the best link,
// relaxes, writes the link back and tracks the next pick on the fly.
// ----------------------------------------------------------------------------
module mbw_prim #(
	parameter int MAX_VERTICES = mbw_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = mbw_pkg::DEF_WEIGHT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]  vtx_active,
	input  logic                               start,
	input  logic                               out_free,
	output logic                               busy,
	// edge store read
	output logic                               scan_en,
	output logic [$clog2(MAX_VERTICES)-1:0]    scan_a,
	output logic [$clog2(MAX_VERTICES)-1:0]    scan_b,
	input  logic                               scan_hit,
	input  logic [WEIGHT_BITS-1:0]             scan_weight,
	// result
	output logic                               graph_done,
	output logic                               res_load,
	output mbw_pkg::result_t                   result
);
	import mbw_pkg::*;

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int LW    = WEIGHT_BITS + 1;
	localparam logic [LW-1:0] INF_LINK = '1;

	prim_state_t state_q, state_d;

	logic [LW-1:0]           best_mem [MAX_VERTICES];
	logic [LW-1:0]           best_rd_q;

	logic [VB-1:0]           pick_q;
	logic [LW-1:0]           bw_q;
	logic                    first_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [WEIGHT_BITS-1:0]  run_max_q;
	logic [CNT_W-1:0]        reached_q;
	logic [VB-1:0]           u_q;
	logic [VB-1:0]           n_last;

	logic                    pass_vld_s1;
	logic [VB-1:0]           u_s1;

	logic [LW-1:0]           min_q;
	logic [VB-1:0]           min_idx_q;
	logic                    min_found_q;

	logic [LW-1:0]           cand;
	logic [LW-1:0]           old_link;
	logic [LW-1:0]           new_link;
	logic                    open_s1;
	logic                    take_min;

	assign n_last = VB'(vtx_active - 1'b1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PS_IDLE: begin
				if (start) begin
					state_d = PS_SELECT;
				end
			end
			PS_SELECT: begin
				state_d = PS_PASS;
			end
			PS_PASS: begin
				if (u_q == n_last) begin
					state_d = PS_DRAIN;
				end
			end
			PS_DRAIN: begin
				state_d = PS_DECIDE;
			end
			PS_DECIDE: begin
				state_d = min_found_q ? PS_SELECT : PS_DONE;
			end
			PS_DONE: begin
				if (out_free) begin
					state_d = PS_IDLE;
				end
			end
			default: begin
				state_d = PS_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		busy       = (state_q != PS_IDLE);
		scan_en    = (state_q == PS_PASS);
		scan_a     = pick_q;
		scan_b     = u_q;
		res_load   = (state_q == PS_DONE) && out_free;
		graph_done = res_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Relax one vertex against the current pick
	assign cand     = scan_hit ? {1'b0, scan_weight} : INF_LINK;
	assign old_link = first_q ? INF_LINK : best_rd_q;
	assign open_s1  = !visited_q[u_s1];
	assign new_link = (open_s1 && (cand < old_link)) ? cand : old_link;
	assign take_min = pass_vld_s1 && open_s1 && (new_link < min_q);

	always_ff @(posedge clk) begin
		if (pass_vld_s1) begin
			best_mem[u_s1] <= new_link;
		end
		best_rd_q <= best_mem[u_q];
		u_s1      <= u_q;
	end

	// Round bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_vld_s1 <= 1'b0;
			pick_q      <= '0;
			bw_q        <= '0;
			first_q     <= 1'b0;
			visited_q   <= '0;
			run_max_q   <= '0;
			reached_q   <= '0;
			u_q         <= '0;
			min_q       <= INF_LINK;
			min_idx_q   <= '0;
			min_found_q <= 1'b0;
		end else begin
			pass_vld_s1 <= (state_q == PS_PASS);
			unique case (state_q)
				PS_IDLE: begin
					if (start) begin
						pick_q    <= '0;
						bw_q      <= '0;
						first_q   <= 1'b1;
						visited_q <= '0;
						run_max_q <= '0;
						reached_q <= '0;
					end
				end
				PS_SELECT: begin
					visited_q[pick_q] <= 1'b1;
					if (bw_q[WEIGHT_BITS-1:0] > run_max_q) begin
						run_max_q <= bw_q[WEIGHT_BITS-1:0];
					end
					reached_q   <= reached_q + 1'b1;
					u_q         <= '0;
					min_q       <= INF_LINK;
					min_found_q <= 1'b0;
				end
				PS_PASS: begin
					u_q <= u_q + 1'b1;
				end
				PS_DECIDE: begin
					if (min_found_q) begin
						pick_q  <= min_idx_q;
						bw_q    <= min_q;
						first_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			// Track the nearest open vertex, lowest index on ties
			if (take_min) begin
				min_q       <= new_link;
				min_idx_q   <= u_s1;
				min_found_q <= 1'b1;
			end
		end
	end

	// Result: disconnected when not every vertex was reached
	always_comb begin
		result.impossible = (reached_q != vtx_active);
		result.max_weight = result.impossible ? '0 : RES_W'(run_max_q);
	end

endmodule

/* rtl/mst_bottleneck_weight.sv */
// ----------------------------------------------------------------------------
// mst_bottleneck_weight
// Largest edge of the minimum spanning tree of a loaded graph.
// ----------------------------------------------------------------------------
// Edges stream in one beat per cycle while s_tready is high; each beat does a
// read-modify-write of the pair's entry in the edge memory, so back-to-back
// beats never stall. The beat with tlast starts the tree walk and the input
// stalls until the result is handed to the output register: the walk runs up
// to n rounds, one per reached vertex (n = clamped vertex_count), each reading
// the edge memory once per vertex, then posts the result. After reset, and
// again after every 255th graph, the edge memory tags are swept once, one entry
// per cycle over 2^(2*ceil(log2(MAX_VERTICES))) entries (4096 at 64 vertices),
// during which no beat is taken; register writes are taken at all times.
// ----------------------------------------------------------------------------
module mst_bottleneck_weight #(
	parameter int MAX_VERTICES = mbw_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = mbw_pkg::DEF_WEIGHT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mbw_pkg::APB_AW-1:0]      paddr,
	input  logic [mbw_pkg::APB_DW-1:0]      pwdata,
	output logic [mbw_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	// edge stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mbw_pkg::S_TDATA_W-1:0]   s_tdata,  // from_vertex, to_vertex, weight, pad
	input  logic [0:0]                      s_tuser,  // edge_valid
	input  logic                            s_tlast,  // last_edge
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mbw_pkg::RES_W-1:0]       m_tdata,  // max_tree_weight
	output logic [0:0]                      m_tuser   // impossible
);
	import mbw_pkg::*;

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	logic [CNT_W-1:0]       vtx_active;
	logic                   s_beat;
	logic                   clearing;
	logic                   busy;
	logic                   out_free;
	logic                   scan_en;
	logic [VB-1:0]          scan_a;
	logic [VB-1:0]          scan_b;
	logic                   scan_hit;
	logic [WEIGHT_BITS-1:0] scan_weight;
	logic                   graph_done;
	logic                   res_load;
	result_t                result;

	logic                   m_tvalid_q;
	result_t                res_q;

	mbw_cfg #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.vtx_active (vtx_active)
	);

	// Take beats while neither sweeping nor walking
	assign s_tready = !clearing && !busy;
	assign s_beat   = s_tvalid && s_tready;

	mbw_edge_store #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_edge_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx_active  (vtx_active),
		.ld_beat     (s_beat && s_tuser[0]),
		.ld_from     (s_tdata[VTX_W-1:0]),
		.ld_to       (s_tdata[2*VTX_W-1:VTX_W]),
		.ld_weight   (s_tdata[2*VTX_W+FLD_WGT_W-1:2*VTX_W]),
		.scan_en     (scan_en),
		.scan_a      (scan_a),
		.scan_b      (scan_b),
		.scan_hit    (scan_hit),
		.scan_weight (scan_weight),
		.graph_done  (graph_done),
		.clearing    (clearing)
	);

	mbw_prim #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_prim (
		.clk         (clk),
		.arst_n      (arst_n),
		.vtx_active  (vtx_active),
		.start       (s_beat && s_tlast),
		.out_free    (out_free),
		.busy        (busy),
		.scan_en     (scan_en),
		.scan_a      (scan_a),
		.scan_b      (scan_b),
		.scan_hit    (scan_hit),
		.scan_weight (scan_weight),
		.graph_done  (graph_done),
		.res_load    (res_load),
		.result      (result)
	);

	// Output register: hold the result beat until taken
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= result;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = res_q.max_weight;
	assign m_tuser[0] = res_q.impossible;

endmodule

/* verif/mst_bottleneck_weight_chk.sv */
// ----------------------------------------------------------------------------
// mst_bottleneck_weight_chk
// Watches the register port and both streams of the spanning-tree bottleneck
// block, keeps its own copy of the loaded graph, computes the bottleneck of
// the minimum spanning tree on every closing beat and compares each result
// beat with the oldest pending answer.
// ----------------------------------------------------------------------------
module mst_bottleneck_weight_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mbw_pkg::APB_AW-1:0]       paddr,
	input  logic [mbw_pkg::APB_DW-1:0]       pwdata,
	input  logic                             pready,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [mbw_pkg::S_TDATA_W-1:0]    s_tdata,  // from_vertex, to_vertex, weight, pad
	input  logic [0:0]                       s_tuser,  // edge_valid
	input  logic                             s_tlast,  // last_edge
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [mbw_pkg::RES_W-1:0]        m_tdata,  // max_tree_weight
	input  logic [0:0]                       m_tuser,  // impossible
	output int                               mismatch_count,
	output int                               results_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mbw_pkg::*;

	localparam int MAXV = DEF_MAX_VERTICES;

	logic [VC_W-1:0]      vertex_cfg;
	logic [FLD_WGT_W-1:0] link_w [MAXV][MAXV];
	bit                   link_on [MAXV][MAXV];
	result_t              bottleneck_q [$];
	result_t              want;

	// Clamp the configured vertex count to the walk size
	function automatic int span_size();
		if (vertex_cfg == '0)
			return 1;
		if (int'(vertex_cfg) > MAXV)
			return MAXV;
		return int'(vertex_cfg);
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < MAXV; i++) begin
			for (int j = 0; j < MAXV; j++) begin
				link_on[i][j] = 1'b0;
				link_w[i][j]  = '0;
			end
		end
	endfunction

	// Store an edge in both directions, keeping the lighter of parallel edges
	function automatic void store_link(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
			logic [FLD_WGT_W-1:0] w);
		int n;
		n = span_size();
		if (w == '0 || a == b || int'(a) >= n || int'(b) >= n)
			return;
		if (!link_on[a][b] || link_w[a][b] > w) begin
			link_w[a][b]  = w;
			link_w[b][a]  = w;
			link_on[a][b] = 1'b1;
			link_on[b][a] = 1'b1;
		end
	endfunction

	// Grow the tree from vertex 0 and track the heaviest edge taken
	function automatic result_t tree_bottleneck();
		int          n;
		int          pick;
		int          joined_cnt;
		logic [16:0] cost [MAXV];
		bit          joined [MAXV];
		logic [16:0] best;
		logic [16:0] peak;
		result_t     r;
		n = span_size();
		for (int v = 0; v < MAXV; v++) begin
			cost[v]   = '1;
			joined[v] = 1'b0;
		end
		cost[0]    = '0;
		peak       = '0;
		joined_cnt = 0;
		while (1) begin
			pick = n;
			best = '1;
			for (int v = 0; v < n; v++) begin
				if (!joined[v] && cost[v] < best) begin
					best = cost[v];
					pick = v;
				end
			end
			if (pick >= n)
				break;
			joined[pick] = 1'b1;
			if (best > peak)
				peak = best;
			joined_cnt++;
			for (int u = 0; u < n; u++) begin
				if (!joined[u] && link_on[pick][u] && {1'b0, link_w[pick][u]} < cost[u])
					cost[u] = {1'b0, link_w[pick][u]};
			end
		end
		r.impossible = (joined_cnt != n);
		r.max_weight = r.impossible ? '0 : peak[RES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_cfg = VC_RESET;
			wipe_graph();
			bottleneck_q.delete();
			mismatch_count  = 0;
			results_pending = 0;
		end else begin
			// check a result beat against the oldest answer
			if (m_tvalid && m_tready) begin
				if (bottleneck_q.size() == 0) begin
					$display("%t unexpected result beat: expected none, got weight %0d impossible %0b",
						$time, m_tdata, m_tuser[0]);
					mismatch_count++;
				end else begin
					want = bottleneck_q.pop_front();
					if (m_tdata !== want.max_weight) begin
						$display("%t max_tree_weight mismatch: expected %0d, got %0d",
							$time, want.max_weight, m_tdata);
						mismatch_count++;
					end
					if (m_tuser[0] !== want.impossible) begin
						$display("%t impossible mismatch: expected %0b, got %0b",
							$time, want.impossible, m_tuser[0]);
						mismatch_count++;
					end
				end
			end
			// track register writes
			if (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_VERTEX_COUNT)
				vertex_cfg = pwdata[VC_W-1:0];
			// load the edge, then solve on the closing beat
			if (s_tvalid && s_tready) begin
				if (s_tuser[0])
					store_link(s_tdata[VTX_W-1:0], s_tdata[2*VTX_W-1:VTX_W],
						s_tdata[2*VTX_W+FLD_WGT_W-1:2*VTX_W]);
				if (s_tlast) begin
					bottleneck_q = {bottleneck_q, tree_bottleneck()};
					wipe_graph();
				end
			end
			results_pending = bottleneck_q.size();
		end
	end

endmodule

/* verif/mst_bottleneck_weight_tb.sv */
// ----------------------------------------------------------------------------
// mst_bottleneck_weight_tb
// Drives graphs of random shape and size into the spanning-tree bottleneck
// block across several vertex counts, with random gaps on both streams and
// one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module mst_bottleneck_weight_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbw_pkg::*;

	localparam int MAXV            = DEF_MAX_VERTICES;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 5000;
	localparam int WATCHDOG_LIMIT  = 40000;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int NUM_PHASES      = 11;
	localparam logic [APB_AW-1:0] VC_ADDR = {REG_VERTEX_COUNT, 2'b00};

	typedef struct packed {
		logic [VTX_W-1:0]     a;
		logic [VTX_W-1:0]     b;
		logic [FLD_WGT_W-1:0] w;
		logic                 valid;
	} link_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [APB_AW-1:0]    paddr    = '0;
	logic [APB_DW-1:0]    pwdata   = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [0:0]           s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [RES_W-1:0]     m_tdata;
	logic [0:0]           m_tuser;

	int                   mismatch_count;
	int                   results_pending;
	int                   tx_idle_pct = 24;
	int                   rx_idle_pct = 63;
	bit                   hold_req    = 1'b0;
	int                   quiet_cycles = 0;
	int                   beats_sent   = 0;
	logic [VC_W-1:0]      vc_now       = VC_RESET;

	mst_bottleneck_weight uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mst_bottleneck_weight_chk bottleneck_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random stalls, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Abort when neither stream moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic link_t link_of(int a, int b, int w, bit v);
		link_t l;
		l.a     = VTX_W'(a);
		l.b     = VTX_W'(b);
		l.w     = FLD_WGT_W'(w);
		l.valid = v;
		return l;
	endfunction

	// Mostly light weights so ties occur, sometimes the full range
	function automatic logic [FLD_WGT_W-1:0] rand_weight();
		case ($urandom_range(9))
			0:       return FLD_WGT_W'($urandom_range(65535));
			1:       return '1;
			default: return FLD_WGT_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic link_t noise_link();
		return link_of($urandom_range(63), $urandom_range(63), $urandom_range(65535),
			$urandom_range(1));
	endfunction

	// Offer one edge beat, with random idle cycles ahead of it
	task automatic push_beat(input link_t l, input bit last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-2*VTX_W-FLD_WGT_W){1'b0}}, l.w, l.b, l.a};
		s_tuser  <= l.valid;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	// Drain, let the block settle, then write the vertex count
	task automatic set_vertices(input int v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= VC_ADDR;
		pwdata  <= APB_DW'(VC_W'(v));
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		vc_now  = VC_W'(v);
	endtask

	// Build one graph over n vertices and stream it, closing with tlast
	task automatic random_graph(input int n);
		link_t links [$];
		link_t tmp;
		int    kind;
		int    cnt;
		int    j;
		bit    close_on_edge;
		kind = $urandom_range(9);
		if (kind <= 6) begin
			// spanning tree with random endpoint order (kind 6 drops some of its edges), plus extra edges
			for (int v = 1; v < n; v++) begin
				if (kind == 6 && $urandom_range(9) == 0)
					continue;
				j = $urandom_range(v - 1);
				if ($urandom_range(1))
					links = {links, link_of(v, j, rand_weight(), 1'b1)};
				else
					links = {links, link_of(j, v, rand_weight(), 1'b1)};
			end
			cnt = $urandom_range(n);
			for (int k = 0; k < cnt; k++)
				links = {links, link_of($urandom_range(n - 1), $urandom_range(n - 1),
					($urandom_range(9) == 0) ? 0 : rand_weight(), $urandom_range(15) != 0)};
		end else if (kind == 7) begin
			cnt = $urandom_range(2 * n);
			for (int k = 0; k < cnt; k++)
				links = {links, link_of($urandom_range(n - 1), $urandom_range(n - 1),
					rand_weight(), 1'b1)};
		end else if (kind == 8) begin
			cnt = $urandom_range(1, 6);
			for (int k = 0; k < cnt; k++)
				links = {links, noise_link()};
		end
		// shuffle the beat order
		for (int k = links.size() - 1; k > 0; k--) begin
			j        = $urandom_range(k);
			tmp      = links[k];
			links[k] = links[j];
			links[j] = tmp;
		end
		close_on_edge = (links.size() > 0) && ($urandom_range(1) == 1);
		foreach (links[k])
			push_beat(links[k], close_on_edge && (k == links.size() - 1));
		if (!close_on_edge)
			push_beat(noise_link(), 1'b1);
	endtask

	initial begin
		int phase_vc [NUM_PHASES];
		int phase_start;
		int n;
		phase_vc = '{3, 64, 8, 2, 127, 20, 1, 12, 0, 40, 6};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex at the reset count: bare closing beat
		push_beat(link_of(0, 0, 0, 1'b0), 1'b1);

		// four vertices: parallel, self-loop, zero weight, out of range, no edge
		set_vertices(4);
		push_beat(link_of(0, 1, 16'hFFFF, 1'b1), 1'b0);
		push_beat(link_of(1, 0, 16'hFFFF, 1'b1), 1'b0);
		push_beat(link_of(1, 2, 1, 1'b1), 1'b0);
		push_beat(link_of(2, 3, 7, 1'b1), 1'b0);
		push_beat(link_of(3, 2, 3, 1'b1), 1'b0);
		push_beat(link_of(3, 3, 1, 1'b1), 1'b0);
		push_beat(link_of(0, 3, 0, 1'b1), 1'b0);
		push_beat(link_of(0, 63, 1, 1'b1), 1'b0);
		push_beat(link_of(63, 63, 16'hFFFF, 1'b0), 1'b0);
		push_beat(link_of(0, 2, 2, 1'b1), 1'b1);
		// heaviest possible tree edge
		push_beat(link_of(1, 0, 16'hFFFF, 1'b1), 1'b0);
		push_beat(link_of(1, 2, 5, 1'b1), 1'b0);
		push_beat(link_of(3, 2, 9, 1'b1), 1'b1);
		// disconnected graph
		push_beat(link_of(0, 1, 5, 1'b1), 1'b0);
		push_beat(link_of(21, 42, 16'h5555, 1'b0), 1'b1);

		// zero count acts as one vertex
		set_vertices(0);
		push_beat(link_of(0, 1, 9, 1'b1), 1'b0);
		push_beat(link_of(0, 0, 1, 1'b1), 1'b1);

		// oversized count saturates to the full vertex range
		set_vertices(127);
		push_beat(link_of(0, 63, 16'hAAAA, 1'b1), 1'b1);

		// random graphs, one vertex count per phase
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_vertices(phase_vc[p]);
			if (p < 4) begin
				tx_idle_pct = 24;
				rx_idle_pct = 63;
			end else if (p < 8) begin
				tx_idle_pct = 63;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			n = (vc_now == 0) ? 1 : ((int'(vc_now) > MAXV) ? MAXV : int'(vc_now));
			phase_start = beats_sent;
			// back up the result side while graphs keep coming
			if (p == 0) begin
				hold_req    = 1'b1;
				tx_idle_pct = 0;
				repeat (16) random_graph(n);
				tx_idle_pct = 24;
			end
			while (beats_sent - phase_start < ITEMS_PER_PHASE)
				random_graph(n);
		end

		// wait out the last results and any stray beats
		rx_idle_pct = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
